@@ design/rccc_pkg.sv @@
// Shared types and constants for the calibrated RGB colour classifier.
// No dependencies; imported by every module of the block.
package rccc_pkg;

    localparam int FREQ_BITS_DEF = 20;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_CH        = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CLS_BITS      = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_BLACK_RED   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLACK_GREEN = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLACK_BLUE  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WHITE_RED   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WHITE_GREEN = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_WHITE_BLUE  = 3'd5;

    localparam logic [CLS_BITS-1:0] CLS_RED     = 3'd0;
    localparam logic [CLS_BITS-1:0] CLS_GREEN   = 3'd1;
    localparam logic [CLS_BITS-1:0] CLS_BLUE    = 3'd2;
    localparam logic [CLS_BITS-1:0] CLS_WHITE   = 3'd3;
    localparam logic [CLS_BITS-1:0] CLS_BLACK   = 3'd4;
    localparam logic [CLS_BITS-1:0] CLS_UNKNOWN = 3'd5;

    typedef struct packed {
        logic              valid;
        logic [NUM_CH-1:0] zero;
        logic [NUM_CH-1:0] full;
    } ctrl_t;

endpackage

@@ design/rccc_prep.sv @@
// Front stage: offsets and spans against calibration, plus zero/full-scale flags.
// Depends on rccc_pkg.
module rccc_prep import rccc_pkg::*; #(
    parameter int FREQ_BITS = FREQ_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic                 in_valid,
    input  logic [FREQ_BITS-1:0] raw   [NUM_CH],
    input  logic [FREQ_BITS-1:0] black [NUM_CH],
    input  logic [FREQ_BITS-1:0] white [NUM_CH],
    output ctrl_t                ctrl_o,
    output logic [FREQ_BITS-1:0] rem_o  [NUM_CH],
    output logic [FREQ_BITS-1:0] span_o [NUM_CH]
);

    ctrl_t                ctrl_reg, ctrl_next;
    logic [FREQ_BITS-1:0] rem_reg  [NUM_CH];
    logic [FREQ_BITS-1:0] rem_next [NUM_CH];
    logic [FREQ_BITS-1:0] span_reg  [NUM_CH];
    logic [FREQ_BITS-1:0] span_next [NUM_CH];

    always_comb begin
        ctrl_next.valid = in_valid;
        for (int c = 0; c < NUM_CH; c++) begin
            ctrl_next.zero[c] = (white[c] <= black[c]) || (raw[c] <= black[c]);
            ctrl_next.full[c] = (raw[c] >= white[c]);
            rem_next[c]       = raw[c] - black[c];
            span_next[c]      = white[c] - black[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (advance) begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rem_reg  <= rem_next;
            span_reg <= span_next;
        end
    end

    assign ctrl_o = ctrl_reg;
    assign rem_o  = rem_reg;
    assign span_o = span_reg;

endmodule

@@ design/rccc_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit for all three channels.
// Depends on rccc_pkg.
module rccc_div_cell import rccc_pkg::*; #(
    parameter int FREQ_BITS = FREQ_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  ctrl_t                ctrl_i,
    input  logic [FREQ_BITS-1:0] rem_i  [NUM_CH],
    input  logic [FREQ_BITS-1:0] span_i [NUM_CH],
    input  logic [FRAC_BITS-1:0] quot_i [NUM_CH],
    output ctrl_t                ctrl_o,
    output logic [FREQ_BITS-1:0] rem_o  [NUM_CH],
    output logic [FREQ_BITS-1:0] span_o [NUM_CH],
    output logic [FRAC_BITS-1:0] quot_o [NUM_CH]
);

    ctrl_t                ctrl_reg;
    logic [FREQ_BITS-1:0] rem_reg  [NUM_CH];
    logic [FREQ_BITS-1:0] rem_next [NUM_CH];
    logic [FREQ_BITS-1:0] span_reg [NUM_CH];
    logic [FRAC_BITS-1:0] quot_reg  [NUM_CH];
    logic [FRAC_BITS-1:0] quot_next [NUM_CH];
    logic [FREQ_BITS:0]   shifted [NUM_CH];
    logic [FREQ_BITS:0]   diff    [NUM_CH];
    logic [NUM_CH-1:0]    ge;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            shifted[c]   = {rem_i[c], 1'b0};
            diff[c]      = shifted[c] - {1'b0, span_i[c]};
            ge[c]        = (shifted[c] >= {1'b0, span_i[c]});
            rem_next[c]  = ge[c] ? diff[c][FREQ_BITS-1:0] : shifted[c][FREQ_BITS-1:0];
            quot_next[c] = {quot_i[c][FRAC_BITS-2:0], ge[c]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (advance) begin
            ctrl_reg <= ctrl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rem_reg  <= rem_next;
            span_reg <= span_i;
            quot_reg <= quot_next;
        end
    end

    assign ctrl_o = ctrl_reg;
    assign rem_o  = rem_reg;
    assign span_o = span_reg;
    assign quot_o = quot_reg;

endmodule

@@ design/rccc_classify.sv @@
// Output stage: saturation, class decision (dominant channel, else white, black or unknown) and result register.
// Depends on rccc_pkg.
module rccc_classify import rccc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  ctrl_t                ctrl_i,
    input  logic [FRAC_BITS-1:0] quot_i [NUM_CH],
    output logic                 out_valid,
    output logic [FRAC_BITS:0]   norm_o [NUM_CH],
    output logic [CLS_BITS-1:0]  class_o
);

    localparam int FULL = 1 << FRAC_BITS;
    localparam logic [FRAC_BITS:0] FULL_SCALE = (FRAC_BITS+1)'(FULL);
    localparam logic [FRAC_BITS:0] T_PRIMARY  = (FRAC_BITS+1)'(FULL / 5);
    localparam logic [FRAC_BITS:0] T_GREEN    = (FRAC_BITS+1)'(FULL / 20);
    localparam logic [FRAC_BITS:0] T_WHITE    = (FRAC_BITS+1)'((FULL * 7) / 20);
    localparam logic [FRAC_BITS:0] T_BLACK    = (FRAC_BITS+1)'(FULL / 10);

    logic                valid_reg;
    logic [FRAC_BITS:0]  norm_reg  [NUM_CH];
    logic [FRAC_BITS:0]  norm_next [NUM_CH];
    logic [CLS_BITS-1:0] class_reg, class_next;
    logic [FRAC_BITS:0]  r, g, b;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (ctrl_i.zero[c]) begin
                norm_next[c] = '0;
            end else if (ctrl_i.full[c]) begin
                norm_next[c] = FULL_SCALE;
            end else begin
                norm_next[c] = {1'b0, quot_i[c]};
            end
        end
        r = norm_next[0];
        g = norm_next[1];
        b = norm_next[2];
        if (r > g && r > b && r > T_PRIMARY) begin
            class_next = CLS_RED;
        end else if (g > r && g > b && g > T_GREEN) begin
            class_next = CLS_GREEN;
        end else if (b > r && b > g && b > T_PRIMARY) begin
            class_next = CLS_BLUE;
        end else if (r > T_WHITE && g > T_WHITE && b > T_WHITE) begin
            class_next = CLS_WHITE;
        end else if (r < T_BLACK && g < T_BLACK && b < T_BLACK) begin
            class_next = CLS_BLACK;
        end else begin
            class_next = CLS_UNKNOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= ctrl_i.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            norm_reg  <= norm_next;
            class_reg <= class_next;
        end
    end

    assign out_valid = valid_reg;
    assign norm_o    = norm_reg;
    assign class_o   = class_reg;

endmodule

@@ design/rgb_calibrated_color_classifier.sv @@
// Calibrated RGB colour classifier: top level with calibration registers and division chain.
// Pipeline: one prep stage, one division cell per quotient bit and one output register.
// Throughput: one beat per cycle while the output register is empty or being taken.
// The whole chain advances together whenever the output register is empty or being taken.
// Reset (aresetn, synchronous): pipeline emptied, black registers 0, white registers 1.
// Depends on rccc_pkg, rccc_prep, rccc_div_cell, rccc_classify.
module rgb_calibrated_color_classifier import rccc_pkg::*; #(
    parameter int FREQ_BITS = FREQ_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int S_W = ((NUM_CH * FREQ_BITS + 7) / 8) * 8,
    localparam int M_W = ((NUM_CH * (FRAC_BITS + 1) + CLS_BITS + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_W-1:0]          s_tdata,   // raw_red, raw_green, raw_blue
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_W-1:0]          m_tdata,   // norm_red, norm_green, norm_blue, color_class
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [FREQ_BITS-1:0]    cfg_data
);

    logic                 advance;
    logic [FREQ_BITS-1:0] black_reg [NUM_CH];
    logic [FREQ_BITS-1:0] white_reg [NUM_CH];
    logic [FREQ_BITS-1:0] raw [NUM_CH];

    ctrl_t                chain_ctrl [FRAC_BITS+1];
    logic [FREQ_BITS-1:0] chain_rem  [FRAC_BITS+1][NUM_CH];
    logic [FREQ_BITS-1:0] chain_span [FRAC_BITS+1][NUM_CH];
    logic [FRAC_BITS-1:0] chain_quot [FRAC_BITS+1][NUM_CH];

    logic [FRAC_BITS:0]   norm [NUM_CH];
    logic [CLS_BITS-1:0]  color_class;

    assign advance   = !m_tvalid || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CH; c++) begin
                black_reg[c] <= '0;
                white_reg[c] <= FREQ_BITS'(1);
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BLACK_RED:   black_reg[0] <= cfg_data;
                REG_BLACK_GREEN: black_reg[1] <= cfg_data;
                REG_BLACK_BLUE:  black_reg[2] <= cfg_data;
                REG_WHITE_RED:   white_reg[0] <= cfg_data;
                REG_WHITE_GREEN: white_reg[1] <= cfg_data;
                REG_WHITE_BLUE:  white_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            raw[c]           = s_tdata[c*FREQ_BITS +: FREQ_BITS];
            chain_quot[0][c] = '0;
        end
    end

    rccc_prep #(
        .FREQ_BITS(FREQ_BITS)
    ) u_prep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_valid(s_tvalid),
        .raw     (raw),
        .black   (black_reg),
        .white   (white_reg),
        .ctrl_o  (chain_ctrl[0]),
        .rem_o   (chain_rem[0]),
        .span_o  (chain_span[0])
    );

    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_cell
        rccc_div_cell #(
            .FREQ_BITS(FREQ_BITS),
            .FRAC_BITS(FRAC_BITS)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .advance(advance),
            .ctrl_i (chain_ctrl[k]),
            .rem_i  (chain_rem[k]),
            .span_i (chain_span[k]),
            .quot_i (chain_quot[k]),
            .ctrl_o (chain_ctrl[k+1]),
            .rem_o  (chain_rem[k+1]),
            .span_o (chain_span[k+1]),
            .quot_o (chain_quot[k+1])
        );
    end

    rccc_classify #(
        .FRAC_BITS(FRAC_BITS)
    ) u_classify (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .ctrl_i   (chain_ctrl[FRAC_BITS]),
        .quot_i   (chain_quot[FRAC_BITS]),
        .out_valid(m_tvalid),
        .norm_o   (norm),
        .class_o  (color_class)
    );

    assign m_tdata = M_W'({color_class, norm[2], norm[1], norm[0]});

endmodule

@@ design/rccc_checker.sv @@
// Port-level checks for the colour classifier, bound to the top level.
// Depends on rccc_pkg and rgb_calibrated_color_classifier.
module rccc_checker import rccc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int M_W = ((NUM_CH * (FRAC_BITS + 1) + CLS_BITS + 7) / 8) * 8,
    localparam int NW  = FRAC_BITS + 1
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_tready,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_W-1:0]          m_tdata
);

    logic [NW-1:0]       nr, ng, nb;
    logic [CLS_BITS-1:0] cls;

    assign nr  = m_tdata[0 +: NW];
    assign ng  = m_tdata[NW +: NW];
    assign nb  = m_tdata[2*NW +: NW];
    assign cls = m_tdata[3*NW +: CLS_BITS];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");

    a_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> cls <= CLS_UNKNOWN)
        else $error("colour class out of range");

    a_red: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cls == CLS_RED |-> nr > ng && nr > nb)
        else $error("red class without dominant red");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!nr[FRAC_BITS] || nr[FRAC_BITS-1:0] == '0)
                  && (!ng[FRAC_BITS] || ng[FRAC_BITS-1:0] == '0)
                  && (!nb[FRAC_BITS] || nb[FRAC_BITS-1:0] == '0))
        else $error("normalised value above full scale");

endmodule

bind rgb_calibrated_color_classifier rccc_checker #(
    .FRAC_BITS(FRAC_BITS)
) u_rccc_checker (.*);
